// ----- rtl/mpq_pkg.sv -----
// Package for the min priority queue: default sizes, opcodes, status codes,
// cell control types and sequencer states. No dependencies.
package mpq_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned DEF_ID_BITS  = 16;
  localparam int unsigned DEF_KEY_BITS = 32;

  // Request opcodes; code 3 is unused and ignored.
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_INSERT   = 2'd0;
  localparam opcode_t OP_EXTRACT  = 2'd1;
  localparam opcode_t OP_DECREASE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  // Broadcast control to every cell of the row.
  typedef struct packed {
    cell_op_e op;
    logic     match_en;
  } mpq_ctl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REINS
  } mpq_state_e;

endpackage

// ----- rtl/mpq_if.sv -----
// Handshake interfaces for the queue's request and response channels.
// Depends on nothing; widths come from the instance parameters.
interface mpq_req_if #(
  parameter int unsigned ID_BITS  = 16,
  parameter int unsigned KEY_BITS = 32
);
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [ID_BITS-1:0]  item_id;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, opcode, item_id, key, input ready);
  modport sink   (input valid, opcode, item_id, key, output ready);
endinterface

interface mpq_rsp_if #(
  parameter int unsigned ID_BITS  = 16,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned CNT_BITS = 7
);
  logic                valid;
  logic                ready;
  logic [ID_BITS-1:0]  out_item_id;
  logic [KEY_BITS-1:0] out_key;
  logic [1:0]          status;
  logic                queue_empty;
  logic [CNT_BITS-1:0] entry_count;

  modport source (output valid, out_item_id, out_key, status, queue_empty, entry_count,
                  input ready);
  modport sink   (input valid, out_item_id, out_key, status, queue_empty, entry_count,
                  output ready);
endinterface

// ----- rtl/mpq_cell.sv -----
// One slot of the sorted row: holds a (key, id) pair and its valid bit.
// Depends on mpq_pkg; neighbors exchange data and the place/hit flags.
module mpq_cell
  import mpq_pkg::*;
#(
  parameter int unsigned ID_BITS  = DEF_ID_BITS,
  parameter int unsigned KEY_BITS = DEF_KEY_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpq_ctl_t            ctl_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [ID_BITS-1:0]  id_i,
  input  logic                left_valid_i,
  input  logic [KEY_BITS-1:0] left_key_i,
  input  logic [ID_BITS-1:0]  left_id_i,
  input  logic                left_place_i,
  input  logic                right_valid_i,
  input  logic [KEY_BITS-1:0] right_key_i,
  input  logic [ID_BITS-1:0]  right_id_i,
  input  logic                hit_i,
  output logic                hit_o,
  output logic                place_o,
  output logic                valid_o,
  output logic [KEY_BITS-1:0] key_o,
  output logic [ID_BITS-1:0]  id_o
);

  logic                valid_q, valid_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [ID_BITS-1:0]  id_q, id_d;

  // new key goes at or before this slot: free slot or strictly larger key
  assign place_o = !valid_q || (key_q > key_i);
  assign hit_o   = hit_i || (ctl_i.match_en && valid_q && (id_q == id_i));

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    id_d    = id_q;
    unique case (ctl_i.op)
      CELL_INSERT: begin
        if (place_o && !left_place_i) begin
          valid_d = 1'b1;
          key_d   = key_i;
          id_d    = id_i;
        end else if (place_o) begin
          valid_d = left_valid_i;
          key_d   = left_key_i;
          id_d    = left_id_i;
        end
      end
      CELL_REMOVE: begin
        if (hit_o) begin
          valid_d = right_valid_i;
          key_d   = right_key_i;
          id_d    = right_id_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    id_q  <= id_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign id_o    = id_q;

endmodule

// ----- rtl/min_priority_queue.sv -----
// Min priority queue top level: sequencer, response register and the row of cells.
// Insert and extract: transfer, then one cell-row update; decrease key: transfer,
// then a remove pass and, on a hit only, a reinsert pass. One at a time.
// A response waits in its register while the next request is transferred.
// Reset (async, active low) empties the queue: all cell valid bits and the count clear.
// Depends on mpq_pkg, mpq_if (mpq_req_if, mpq_rsp_if) and mpq_cell.
module min_priority_queue
  import mpq_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY,
  parameter int unsigned ID_BITS  = DEF_ID_BITS,
  parameter int unsigned KEY_BITS = DEF_KEY_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mpq_req_if.sink   req_i,
  mpq_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // ---------------------------------------------------------------------------
  // Sequencer state and latched request
  // ---------------------------------------------------------------------------
  mpq_state_e          state_q, state_d;
  opcode_t             op_q;
  logic [ID_BITS-1:0]  id_q;
  logic [KEY_BITS-1:0] key_q;
  logic [CNT_W-1:0]    count_q, count_d;

  // response register
  logic                out_valid_q, out_valid_d;
  logic [ID_BITS-1:0]  out_id_q, out_id_d;
  logic [KEY_BITS-1:0] out_key_q, out_key_d;
  status_e             status_q, status_d;
  logic [CNT_W-1:0]    out_cnt_q;
  logic                out_load;

  logic req_xfer;
  logic rsp_xfer;
  logic out_free;

  // cell row
  mpq_ctl_t            ctl;
  logic                hit_head;
  logic                cell_valid [CAPACITY];
  logic [KEY_BITS-1:0] cell_key   [CAPACITY];
  logic [ID_BITS-1:0]  cell_id    [CAPACITY];
  logic                cell_place [CAPACITY];
  logic                hit_chain  [CAPACITY+1];
  logic [CAPACITY-1:0] valid_vec;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign rsp_xfer    = rsp_o.valid && rsp_o.ready;
  // response slot is free now or is emptied at this edge
  assign out_free    = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      op_q  <= req_i.opcode;
      id_q  <= req_i.item_id;
      key_q <= req_i.key;
    end
  end

  // ---------------------------------------------------------------------------
  // Next state, cell control and response
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ctl.op       = CELL_HOLD;
    ctl.match_en = 1'b0;
    hit_head     = 1'b0;
    out_load     = 1'b0;
    out_id_d     = '0;
    out_key_d    = '0;
    status_d     = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          unique case (op_q)
            OP_INSERT: begin
              if (count_q == CAP_CNT) begin
                status_d = ST_FULL;
              end else begin
                ctl.op  = CELL_INSERT;
                count_d = count_q + CNT_W'(1);
              end
            end
            OP_EXTRACT: begin
              if (count_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                // forced hit at the head: whole row moves one slot up
                ctl.op    = CELL_REMOVE;
                hit_head  = 1'b1;
                out_id_d  = cell_id[0];
                out_key_d = cell_key[0];
                count_d   = count_q - CNT_W'(1);
              end
            end
            OP_DECREASE: begin
              // first matching id pulls everything behind it up one slot
              ctl.op       = CELL_REMOVE;
              ctl.match_en = 1'b1;
              if (hit_chain[CAPACITY]) begin
                count_d  = count_q - CNT_W'(1);
                out_load = 1'b0;
                state_d  = S_REINS;
              end else begin
                status_d = ST_MISS;
              end
            end
            default: ;
          endcase
        end
      end
      S_REINS: begin
        if (out_free) begin
          ctl.op   = CELL_INSERT;
          count_d  = count_q + CNT_W'(1);
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_xfer) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_id_q  <= out_id_d;
      out_key_q <= out_key_d;
      status_q  <= status_d;
      out_cnt_q <= count_d;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.out_item_id = out_id_q;
  assign rsp_o.out_key     = out_key_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.queue_empty = (out_cnt_q == '0);
  assign rsp_o.entry_count = out_cnt_q;

  // ---------------------------------------------------------------------------
  // Row of cells, slot 0 holds the smallest key
  // ---------------------------------------------------------------------------
  assign hit_chain[0] = hit_head;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                l_valid, l_place, r_valid;
    logic [KEY_BITS-1:0] l_key, r_key;
    logic [ID_BITS-1:0]  l_id, r_id;

    if (i == 0) begin : g_head
      assign l_valid = 1'b0;
      assign l_key   = '0;
      assign l_id    = '0;
      assign l_place = 1'b0;
    end else begin : g_left
      assign l_valid = cell_valid[i-1];
      assign l_key   = cell_key[i-1];
      assign l_id    = cell_id[i-1];
      assign l_place = cell_place[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_key   = '0;
      assign r_id    = '0;
    end else begin : g_right
      assign r_valid = cell_valid[i+1];
      assign r_key   = cell_key[i+1];
      assign r_id    = cell_id[i+1];
    end

    mpq_cell #(
      .ID_BITS  (ID_BITS),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .key_i         (key_q),
      .id_i          (id_q),
      .left_valid_i  (l_valid),
      .left_key_i    (l_key),
      .left_id_i     (l_id),
      .left_place_i  (l_place),
      .right_valid_i (r_valid),
      .right_key_i   (r_key),
      .right_id_i    (r_id),
      .hit_i         (hit_chain[i]),
      .hit_o         (hit_chain[i+1]),
      .place_o       (cell_place[i]),
      .valid_o       (cell_valid[i]),
      .key_o         (cell_key[i]),
      .id_o          (cell_id[i])
    );

    assign valid_vec[i] = cell_valid[i];
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("entry count above capacity");

  a_count_matches_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(count_q))
    else $error("count disagrees with occupied cells");

  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_valid[0] == (count_q != '0))
    else $error("head cell occupancy disagrees with count");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_xfer |=> !req_i.ready)
    else $error("request taken while another is in flight");

  a_row_quiet_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> $stable(count_q))
    else $error("count moved without a request");

endmodule

// ----- bench/min_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for min_priority_queue: directed table, then phased random traffic.
// Depends on mpq_pkg, mpq_if and the RTL top; expected responses come from an in-bench queue.
module min_priority_queue_tb;
  import mpq_pkg::*;

  localparam int unsigned CAP   = DEF_CAPACITY;
  localparam int unsigned ID_W  = DEF_ID_BITS;
  localparam int unsigned KEY_W = DEF_KEY_BITS;
  localparam int unsigned CNT_W = $clog2(CAP + 1);
  localparam int unsigned RANDOM_ITEMS = 2000;

  // Code 3 has no package name; the block treats it as a no-op.
  localparam opcode_t OP_UNUSED = 2'd3;

  typedef struct packed {
    opcode_t              opcode;
    logic [ID_W-1:0]      item_id;
    logic [KEY_W-1:0]     key;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0]      item_id;
    logic [KEY_W-1:0]     key;
    status_e              status;
    logic                 empty;
    logic [CNT_W-1:0]     count;
  } response_t;

  // One line of the directed table. Where typed is set, rsp is what the block
  // must return; otherwise the shadow queue decides.
  typedef struct packed {
    request_t  req;
    logic      typed;
    response_t rsp;
  } row_t;

  typedef enum logic [1:0] {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED
  } phase_e;

  localparam int unsigned N_ROWS = 24;

  // Directed stimulus, walked in order straight out of reset.
  row_t directed_rows [N_ROWS] = '{
    // empty queue: extract, rekey of an absent id, unused opcode
    '{'{OP_EXTRACT,  16'h0000, 32'h0000_0000}, 1'b1, '{16'h0, 32'h0, ST_EMPTY, 1'b1, 7'd0}},
    '{'{OP_DECREASE, 16'h0005, 32'h0000_0000}, 1'b1, '{16'h0, 32'h0, ST_MISS,  1'b1, 7'd0}},
    '{'{OP_UNUSED,   16'hFFFF, 32'hFFFF_FFFF}, 1'b1, '{16'h0, 32'h0, ST_OK,    1'b1, 7'd0}},
    // largest id and key in and straight back out
    '{'{OP_INSERT,   16'hFFFF, 32'hFFFF_FFFF}, 1'b1, '{16'h0, 32'h0, ST_OK,    1'b0, 7'd1}},
    '{'{OP_EXTRACT,  16'h0000, 32'h0000_0000}, 1'b1,
      '{16'hFFFF, 32'hFFFF_FFFF, ST_OK, 1'b1, 7'd0}},
    '{'{OP_INSERT,   16'h0000, 32'h0000_0000}, 1'b1, '{16'h0, 32'h0, ST_OK,    1'b0, 7'd1}},
    // equal keys must leave in arrival order; id 1 shows up twice
    '{'{OP_INSERT,   16'h0001, 32'h0001_8000}, 1'b0, '0},
    '{'{OP_INSERT,   16'h0002, 32'h0001_8000}, 1'b0, '0},
    '{'{OP_INSERT,   16'h0003, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{OP_INSERT,   16'h0001, 32'h0001_0000}, 1'b0, '0},
    // rekey hits the copy of id 1 nearest the head; new key may also grow
    '{'{OP_DECREASE, 16'h0001, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_DECREASE, 16'h0003, 32'h0000_8000}, 1'b0, '0},
    '{'{OP_DECREASE, 16'h0002, 32'hFFFF_FFFF}, 1'b0, '0},
    '{'{OP_DECREASE, 16'h7777, 32'h1234_5678}, 1'b0, '0},
    '{'{OP_INSERT,   16'hAAAA, 32'h5555_5555}, 1'b0, '0},
    '{'{OP_INSERT,   16'h5555, 32'hAAAA_AAAA}, 1'b0, '0},
    // drain everything, then one more extract on the empty queue
    '{'{OP_EXTRACT,  16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT,  16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT,  16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT,  16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT,  16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT,  16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT,  16'h0000, 32'h0000_0000}, 1'b0, '0},
    '{'{OP_EXTRACT,  16'h0000, 32'h0000_0000}, 1'b0, '0}
  };

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic sink_ready = 1'b0;
  // Set during the long stretch where neither side idles.
  bit   steady = 1'b0;
  int   mismatches = 0;

  // Shadow copy of the sorted slot array; slot 0 holds the smallest key.
  logic [KEY_W-1:0] held_key [CAP];
  logic [ID_W-1:0]  held_id  [CAP];
  int unsigned      held_count = 0;

  // Responses owed by the block, oldest first.
  response_t due_responses [$];

  mpq_req_if #(.ID_BITS(ID_W), .KEY_BITS(KEY_W)) req ();
  mpq_rsp_if #(.ID_BITS(ID_W), .KEY_BITS(KEY_W), .CNT_BITS(CNT_W)) rsp ();

  assign rsp.ready = sink_ready;

  min_priority_queue #(
    .CAPACITY (CAP),
    .ID_BITS  (ID_W),
    .KEY_BITS (KEY_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Place a pair behind every entry whose key is equal or lower.
  function automatic void place_sorted(logic [ID_W-1:0] id, logic [KEY_W-1:0] k);
    int unsigned pos;
    pos = 0;
    while (pos < held_count && held_key[pos] <= k) pos++;
    for (int unsigned i = held_count; i > pos; i--) begin
      held_key[i] = held_key[i-1];
      held_id[i]  = held_id[i-1];
    end
    held_key[pos] = k;
    held_id[pos]  = id;
    held_count++;
  endfunction

  function automatic void drop_slot(int unsigned pos);
    for (int unsigned i = pos; i + 1 < held_count; i++) begin
      held_key[i] = held_key[i+1];
      held_id[i]  = held_id[i+1];
    end
    held_count--;
  endfunction

  // Apply one request to the shadow queue and return the response it owes.
  function automatic response_t apply_op(request_t r);
    response_t res;
    int        hit;
    res = '0;
    res.status = ST_OK;
    case (r.opcode)
      OP_INSERT: begin
        if (held_count >= CAP) res.status = ST_FULL;
        else place_sorted(r.item_id, r.key);
      end
      OP_EXTRACT: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.item_id = held_id[0];
          res.key     = held_key[0];
          drop_slot(0);
        end
      end
      OP_DECREASE: begin
        hit = -1;
        for (int i = 0; i < int'(held_count); i++)
          if (hit < 0 && held_id[i] == r.item_id) hit = i;
        if (hit < 0) begin
          res.status = ST_MISS;
        end else begin
          drop_slot(hit);
          place_sorted(r.item_id, r.key);
        end
      end
      default: ;
    endcase
    res.empty = (held_count == 0);
    res.count = held_count[CNT_W-1:0];
    return res;
  endfunction

  // Present one request, hold it until transferred, and return the prediction.
  // valid is left high so back-to-back requests need no toggle.
  task automatic send_request(input request_t r, output response_t predicted);
    if (!steady && $urandom_range(99) < 26) begin
      req.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 26);
    end
    req.valid   <= 1'b1;
    req.opcode  <= r.opcode;
    req.item_id <= r.item_id;
    req.key     <= r.key;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    predicted = apply_op(r);
  endtask

  task automatic check_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Response side: check every transfer against the oldest expectation, then
  // choose ready for the next edge. Values are sampled as they stood before
  // the edge, so ordering among processes does not matter.
  always @(posedge clk_i) begin
    response_t want;
    if (rst_ni && rsp.valid === 1'b1 && sink_ready) begin
      if (due_responses.size() == 0) begin
        $display("%0t ns: response with none outstanding, id 0x%0h key 0x%0h status %0d",
                 $time, rsp.out_item_id, rsp.out_key, rsp.status);
        mismatches++;
      end else begin
        want = due_responses.pop_front();
        check_field("out_item_id", KEY_W'(want.item_id), KEY_W'(rsp.out_item_id));
        check_field("out_key",     want.key,             rsp.out_key);
        check_field("status",      KEY_W'(want.status),  KEY_W'(rsp.status));
        check_field("queue_empty", KEY_W'(want.empty),   KEY_W'(rsp.queue_empty));
        check_field("entry_count", KEY_W'(want.count),   KEY_W'(rsp.entry_count));
      end
    end
    sink_ready <= steady || ($urandom_range(99) >= 26);
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(5_000_000);
    $display("[min_priority_queue] ERROR");
    $finish;
  end

  initial begin
    request_t    r;
    response_t   predicted;
    phase_e      kind;
    int unsigned phase_left;
    int unsigned pick;

    req.valid   = 1'b0;
    req.opcode  = OP_INSERT;
    req.item_id = '0;
    req.key     = '0;
    kind        = PH_MIXED;
    phase_left  = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, predicted);
      if (directed_rows[i].typed) due_responses.push_back(directed_rows[i].rsp);
      else due_responses.push_back(predicted);
    end

    // Random traffic in phases: fill phases push the queue toward the full
    // condition, drain phases push it toward empty, mixed phases churn.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      // Hold off until the block has answered everything, twice in the run.
      if (n == 0 || n == 500) begin
        req.valid <= 1'b0;
        while (due_responses.size() != 0) @(posedge clk_i);
      end
      steady = (n >= 900 && n < 1200);

      if (phase_left == 0) begin
        pick = $urandom_range(2);
        kind = (pick == 0) ? PH_FILL : (pick == 1) ? PH_DRAIN : PH_MIXED;
        phase_left = $urandom_range(200, 40);
      end
      phase_left--;

      pick = $urandom_range(99);
      if (pick < 2) begin
        r.opcode = OP_UNUSED;
      end else begin
        case (kind)
          PH_FILL:  r.opcode = (pick < 75) ? OP_INSERT : (pick < 87) ? OP_EXTRACT : OP_DECREASE;
          PH_DRAIN: r.opcode = (pick < 15) ? OP_INSERT : (pick < 80) ? OP_EXTRACT : OP_DECREASE;
          default:  r.opcode = (pick < 40) ? OP_INSERT : (pick < 70) ? OP_EXTRACT : OP_DECREASE;
        endcase
      end

      // Mostly a small id pool so duplicates and rekey hits are common;
      // rekeys usually name an id that is actually stored.
      pick = $urandom_range(99);
      if (r.opcode == OP_DECREASE && held_count != 0 && pick < 70)
        r.item_id = held_id[$urandom_range(held_count - 1)];
      else if (pick < 75)
        r.item_id = ID_W'($urandom_range(15));
      else
        r.item_id = ID_W'($urandom_range(16'hFFFF));

      // Coarse keys give plenty of ties; the rest covers extremes and full range.
      pick = $urandom_range(99);
      if (pick < 40)      r.key = KEY_W'($urandom_range(7)) << 16;
      else if (pick < 45) r.key = '0;
      else if (pick < 50) r.key = '1;
      else                r.key = KEY_W'($urandom());

      send_request(r, predicted);
      due_responses.push_back(predicted);
    end
    steady = 1'b0;

    // Drain: wait for every owed response, then keep idling to catch
    // anything extra the block might still push out.
    req.valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0 && due_responses.size() == 0) begin
      $display("[min_priority_queue] OK");
    end else begin
      $display("[min_priority_queue] ERROR");
    end
    $finish;
  end

endmodule
